// ----- rtl/susf_pkg.sv -----
// ----------------------------------------------------------------------------
// susf_pkg
// Shared constants, types and codes of the shortest unique substring finder.
// ----------------------------------------------------------------------------
`default_nettype none

package susf_pkg;

	localparam int MAX_NUMBERS   = 1024;
	localparam int NUMBER_LENGTH = 9;
	localparam int ALPHABET_SIZE = 10;

	localparam int MAX_STATES = 2 * MAX_NUMBERS * NUMBER_LENGTH + 1;

	localparam int ST_W    = $clog2(MAX_STATES);
	localparam int CNT_W   = $clog2(MAX_STATES + 1);
	localparam int LEN_W   = $clog2(NUMBER_LENGTH + 1);
	localparam int POS_W   = $clog2(NUMBER_LENGTH + 1);
	localparam int BEST_W  = $clog2(NUMBER_LENGTH + 2);
	localparam int DIDX_W  = (NUMBER_LENGTH > 1) ? $clog2(NUMBER_LENGTH) : 1;
	localparam int SYM_W   = $clog2(ALPHABET_SIZE);
	localparam int NUM_W   = $clog2(MAX_NUMBERS + 1);
	localparam int OWN_W   = NUM_W + 1;
	localparam int DA_W    = $clog2(MAX_NUMBERS * NUMBER_LENGTH);
	localparam int ROW_W   = ALPHABET_SIZE * ST_W;
	localparam int INFO_W  = ST_W + LEN_W;

	localparam int OP_W    = 2;
	localparam int DIGIT_W = 4;
	localparam int IDX_W   = 11;
	localparam int OPOS_W  = 4;

	localparam logic [OWN_W-1:0] SHARED_MARK = '1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_FINAL = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef logic [ALPHABET_SIZE-1:0][ST_W-1:0] row_t;

	typedef struct packed {
		logic [ST_W-1:0]  link;
		logic [LEN_W-1:0] len;
	} info_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_E_LAST,
		ST_E_WALK,
		ST_E_Q,
		ST_E_SPLIT,
		ST_E_SWALK,
		ST_F_CLEAR,
		ST_W_DIG,
		ST_W_ROOT,
		ST_W_STEP,
		ST_Q_EMIT
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/susf_ram.sv -----
// ----------------------------------------------------------------------------
// susf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module susf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/shortest_unique_substring_finder_unit.sv -----
// ----------------------------------------------------------------------------
// shortest_unique_substring_finder_unit
// Generalized suffix automaton over fixed-length decimal numbers with
// per-state ownership marks and shortest unique substring queries.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one transaction per item: op selects
// load digit, finalize or query. Only a query makes an output transaction
// (out_valid/out_ready) carrying found, start_pos and end_pos.
// One item is worked on at a time; in_ready is high only while idle.
// Load: reads the last state, then follows suffix links; when a state is
// cloned it writes the clone and makes a second suffix link walk.
// Finalize: sweeps the owner marks of all MAX_STATES states, then per number
// fetches its digits and walks the substrings from each start position.
// Query: walks the substrings of the named number the same way, reading the
// transition memory once per step.
// Reset starts a sweep over all MAX_STATES states that zeroes the transition,
// link and owner memories; in_ready stays low until it ends.
// A finished result sits in an output register, so the next item is accepted
// while out_ready is low; a second query result waits until the first leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_unique_substring_finder_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [susf_pkg::OP_W-1:0]    op,
	input  wire logic [susf_pkg::DIGIT_W-1:0] digit,
	input  wire logic [susf_pkg::IDX_W-1:0]   number_index,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              found,
	output logic      [susf_pkg::OPOS_W-1:0]  start_pos,
	output logic      [susf_pkg::OPOS_W-1:0]  end_pos
);

	localparam int NL = susf_pkg::NUMBER_LENGTH;

	susf_pkg::state_t state_q, state_d;

	logic                          trans_we, trans_re;
	logic [susf_pkg::ST_W-1:0]     trans_waddr, trans_raddr;
	susf_pkg::row_t                trans_wdata, row_rd;
	logic                          info_we, info_re;
	logic [susf_pkg::ST_W-1:0]     info_waddr, info_raddr;
	susf_pkg::info_t               info_wdata, info_rd;
	logic                          own_we, own_re;
	logic [susf_pkg::ST_W-1:0]     own_waddr, own_raddr;
	logic [susf_pkg::OWN_W-1:0]    own_wdata, own_rd;
	logic                          dig_we, dig_re;
	logic [susf_pkg::DA_W-1:0]     dig_raddr;
	logic [susf_pkg::SYM_W-1:0]    dig_rd;

	logic [susf_pkg::ST_W-1:0]     clr_q;
	logic [susf_pkg::CNT_W-1:0]    count_q;
	logic [susf_pkg::ST_W-1:0]     last_q;
	logic [susf_pkg::NUM_W-1:0]    numbers_q;
	logic [susf_pkg::POS_W-1:0]    pos_q;
	logic [susf_pkg::DA_W-1:0]     dwr_q;
	logic                          out_valid_q;

	logic [susf_pkg::SYM_W-1:0]    c_q;
	logic                          wrap_q;
	logic [susf_pkg::ST_W-1:0]     p_q, q_q, cur_q, nq_q;
	logic [susf_pkg::LEN_W-1:0]    cur_len_q, len_p_q, len_q_q;
	logic                          split_last_q;

	logic                          fin_q;
	logic [susf_pkg::IDX_W-1:0]    walk_id_q;
	logic [susf_pkg::DA_W-1:0]     base_q;
	logic [susf_pkg::POS_W-1:0]    t_q, j_q, k_q;
	logic [susf_pkg::SYM_W-1:0]    dig_q [NL];
	logic [susf_pkg::ST_W-1:0]     x_q;
	logic                          have_x_q;
	logic [susf_pkg::BEST_W-1:0]   best_q;
	logic [susf_pkg::POS_W-1:0]    lo_q, hi_q;
	logic                          found_q;
	logic [susf_pkg::OPOS_W-1:0]   start_q, end_q;

	logic                          accept, load_ok, range_ok;
	logic [susf_pkg::ST_W-1:0]     tgt_c;
	logic [susf_pkg::SYM_W-1:0]    walk_dig;
	logic [susf_pkg::ST_W-1:0]     walk_nx;
	logic                          walk_end, last_k, emit;
	logic [susf_pkg::OWN_W-1:0]    walk_id_own, new_mark;
	logic [susf_pkg::POS_W-1:0]    sub_len;
	logic                          better;
	logic                          ext_done;
	logic [susf_pkg::ST_W-1:0]     ext_last;
	logic [susf_pkg::LEN_W-1:0]    len_p1;

	susf_ram #(.WIDTH(susf_pkg::ROW_W), .DEPTH(susf_pkg::MAX_STATES)) u_trans (
		.clk  (clk),
		.we   (trans_we),
		.waddr(trans_waddr),
		.wdata(trans_wdata),
		.re   (trans_re),
		.raddr(trans_raddr),
		.rdata(row_rd)
	);

	susf_ram #(.WIDTH(susf_pkg::INFO_W), .DEPTH(susf_pkg::MAX_STATES)) u_info (
		.clk  (clk),
		.we   (info_we),
		.waddr(info_waddr),
		.wdata(info_wdata),
		.re   (info_re),
		.raddr(info_raddr),
		.rdata(info_rd)
	);

	susf_ram #(.WIDTH(susf_pkg::OWN_W), .DEPTH(susf_pkg::MAX_STATES)) u_own (
		.clk  (clk),
		.we   (own_we),
		.waddr(own_waddr),
		.wdata(own_wdata),
		.re   (own_re),
		.raddr(own_raddr),
		.rdata(own_rd)
	);

	susf_ram #(
		.WIDTH(susf_pkg::SYM_W),
		.DEPTH(susf_pkg::MAX_NUMBERS * susf_pkg::NUMBER_LENGTH)
	) u_digits (
		.clk  (clk),
		.we   (dig_we),
		.waddr(dwr_q),
		.wdata(susf_pkg::SYM_W'(digit)),
		.re   (dig_re),
		.raddr(dig_raddr),
		.rdata(dig_rd)
	);

	assign in_ready  = (state_q == susf_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign start_pos = start_q;
	assign end_pos   = end_q;

	assign load_ok = (32'(digit) < susf_pkg::ALPHABET_SIZE)
		&& (32'(numbers_q) < susf_pkg::MAX_NUMBERS)
		&& (32'(count_q) + 32'd2 <= susf_pkg::MAX_STATES);
	assign range_ok = (number_index != '0) && (32'(number_index) <= 32'(numbers_q));

	assign tgt_c    = row_rd[c_q];
	assign walk_dig = (32'(j_q) < NL) ? dig_q[susf_pkg::DIDX_W'(j_q)] : '0;
	assign walk_nx  = row_rd[walk_dig];
	assign walk_end = (32'(j_q) >= NL) || (walk_nx == '0);
	assign last_k   = (32'(k_q) == NL - 1);
	assign emit     = !out_valid_q || out_ready;
	assign len_p1   = susf_pkg::LEN_W'(len_p_q + 1'b1);

	assign walk_id_own = susf_pkg::OWN_W'(walk_id_q);
	assign sub_len     = susf_pkg::POS_W'(j_q - k_q);
	assign better      = (own_rd == walk_id_own)
		&& (susf_pkg::BEST_W'(sub_len) < best_q);

	always_comb begin
		if (own_rd == '0 || own_rd == walk_id_own) begin
			new_mark = walk_id_own;
		end else begin
			new_mark = susf_pkg::SHARED_MARK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= susf_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		trans_we    = 1'b0;
		trans_waddr = '0;
		trans_wdata = row_rd;
		trans_re    = 1'b0;
		trans_raddr = '0;
		info_we     = 1'b0;
		info_waddr  = '0;
		info_wdata  = '0;
		info_re     = 1'b0;
		info_raddr  = '0;
		own_we      = 1'b0;
		own_waddr   = '0;
		own_wdata   = '0;
		own_re      = 1'b0;
		own_raddr   = '0;
		dig_we      = 1'b0;
		dig_re      = 1'b0;
		dig_raddr   = susf_pkg::DA_W'(base_q + susf_pkg::DA_W'(t_q));
		ext_done    = 1'b0;
		ext_last    = cur_q;
		unique case (state_q)
			susf_pkg::ST_CLEAR: begin
				trans_we    = 1'b1;
				trans_waddr = clr_q;
				trans_wdata = '0;
				info_we     = 1'b1;
				info_waddr  = clr_q;
				own_we      = 1'b1;
				own_waddr   = clr_q;
				if (32'(clr_q) == susf_pkg::MAX_STATES - 1) begin
					state_d = susf_pkg::ST_IDLE;
				end
			end
			susf_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (op)
						susf_pkg::OP_LOAD: begin
							if (load_ok) begin
								dig_we      = 1'b1;
								trans_re    = 1'b1;
								trans_raddr = last_q;
								info_re     = 1'b1;
								info_raddr  = last_q;
								state_d     = susf_pkg::ST_E_LAST;
							end
						end
						susf_pkg::OP_FINAL: state_d = susf_pkg::ST_F_CLEAR;
						susf_pkg::OP_QUERY: begin
							state_d = range_ok ? susf_pkg::ST_W_DIG : susf_pkg::ST_Q_EMIT;
						end
						default: state_d = susf_pkg::ST_IDLE;
					endcase
				end
			end
			susf_pkg::ST_E_LAST: begin
				if (tgt_c != '0) begin
					trans_re    = 1'b1;
					trans_raddr = tgt_c;
					info_re     = 1'b1;
					info_raddr  = tgt_c;
					state_d     = susf_pkg::ST_E_Q;
				end else begin
					state_d = susf_pkg::ST_E_WALK;
				end
			end
			susf_pkg::ST_E_WALK: begin
				if (tgt_c != '0) begin
					trans_re    = 1'b1;
					trans_raddr = tgt_c;
					info_re     = 1'b1;
					info_raddr  = tgt_c;
					state_d     = susf_pkg::ST_E_Q;
				end else begin
					trans_we           = 1'b1;
					trans_waddr        = p_q;
					trans_wdata        = row_rd;
					trans_wdata[c_q]   = cur_q;
					if (p_q == '0) begin
						info_we    = 1'b1;
						info_waddr = cur_q;
						info_wdata = '{link: '0, len: cur_len_q};
						ext_done   = 1'b1;
						state_d    = susf_pkg::ST_IDLE;
					end else begin
						trans_re    = 1'b1;
						trans_raddr = info_rd.link;
						info_re     = 1'b1;
						info_raddr  = info_rd.link;
					end
				end
			end
			susf_pkg::ST_E_Q: begin
				if (info_rd.len == len_p1) begin
					ext_done = 1'b1;
					state_d  = susf_pkg::ST_IDLE;
					if (split_last_q) begin
						ext_last = q_q;
					end else begin
						info_we    = 1'b1;
						info_waddr = cur_q;
						info_wdata = '{link: q_q, len: cur_len_q};
					end
				end else begin
					trans_we    = 1'b1;
					trans_waddr = susf_pkg::ST_W'(count_q);
					trans_wdata = row_rd;
					info_we     = 1'b1;
					info_waddr  = susf_pkg::ST_W'(count_q);
					info_wdata  = '{link: info_rd.link, len: len_p1};
					state_d     = susf_pkg::ST_E_SPLIT;
				end
			end
			susf_pkg::ST_E_SPLIT: begin
				info_we     = 1'b1;
				info_waddr  = q_q;
				info_wdata  = '{link: nq_q, len: len_q_q};
				trans_re    = 1'b1;
				trans_raddr = p_q;
				info_re     = 1'b1;
				info_raddr  = p_q;
				state_d     = susf_pkg::ST_E_SWALK;
			end
			susf_pkg::ST_E_SWALK: begin
				if (tgt_c == q_q) begin
					trans_we         = 1'b1;
					trans_waddr      = p_q;
					trans_wdata      = row_rd;
					trans_wdata[c_q] = nq_q;
				end
				if (tgt_c != q_q || p_q == '0) begin
					ext_done = 1'b1;
					state_d  = susf_pkg::ST_IDLE;
					if (split_last_q) begin
						ext_last = nq_q;
					end else begin
						info_we    = 1'b1;
						info_waddr = cur_q;
						info_wdata = '{link: nq_q, len: cur_len_q};
					end
				end else begin
					trans_re    = 1'b1;
					trans_raddr = info_rd.link;
					info_re     = 1'b1;
					info_raddr  = info_rd.link;
				end
			end
			susf_pkg::ST_F_CLEAR: begin
				own_we    = 1'b1;
				own_waddr = clr_q;
				if (32'(clr_q) == susf_pkg::MAX_STATES - 1) begin
					state_d = (numbers_q == '0) ? susf_pkg::ST_IDLE : susf_pkg::ST_W_DIG;
				end
			end
			susf_pkg::ST_W_DIG: begin
				if (32'(t_q) < NL) begin
					dig_re = 1'b1;
				end else begin
					state_d = susf_pkg::ST_W_ROOT;
				end
			end
			susf_pkg::ST_W_ROOT: begin
				trans_re    = 1'b1;
				trans_raddr = '0;
				state_d     = susf_pkg::ST_W_STEP;
			end
			susf_pkg::ST_W_STEP: begin
				if (have_x_q && fin_q) begin
					own_we    = 1'b1;
					own_waddr = x_q;
					own_wdata = new_mark;
				end
				if (!walk_end) begin
					trans_re    = 1'b1;
					trans_raddr = walk_nx;
					own_re      = 1'b1;
					own_raddr   = walk_nx;
				end else if (!last_k) begin
					state_d = susf_pkg::ST_W_ROOT;
				end else if (!fin_q) begin
					state_d = susf_pkg::ST_Q_EMIT;
				end else if (32'(walk_id_q) == 32'(numbers_q)) begin
					state_d = susf_pkg::ST_IDLE;
				end else begin
					state_d = susf_pkg::ST_W_DIG;
				end
			end
			susf_pkg::ST_Q_EMIT: begin
				if (emit) begin
					state_d = susf_pkg::ST_IDLE;
				end
			end
			default: state_d = susf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			count_q     <= susf_pkg::CNT_W'(1);
			last_q      <= '0;
			numbers_q   <= '0;
			pos_q       <= '0;
			dwr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == susf_pkg::ST_CLEAR || state_q == susf_pkg::ST_F_CLEAR) begin
				clr_q <= susf_pkg::ST_W'(clr_q + 1'b1);
			end
			if (accept && op == susf_pkg::OP_FINAL) begin
				clr_q <= '0;
			end
			if (accept && op == susf_pkg::OP_LOAD && load_ok) begin
				dwr_q <= susf_pkg::DA_W'(dwr_q + 1'b1);
				if (32'(pos_q) == NL - 1) begin
					pos_q     <= '0;
					numbers_q <= susf_pkg::NUM_W'(numbers_q + 1'b1);
				end else begin
					pos_q <= susf_pkg::POS_W'(pos_q + 1'b1);
				end
			end
			if ((state_q == susf_pkg::ST_E_LAST && tgt_c == '0)
				|| (state_q == susf_pkg::ST_E_Q && info_rd.len != len_p1)) begin
				count_q <= susf_pkg::CNT_W'(count_q + 1'b1);
			end
			if (ext_done) begin
				last_q <= wrap_q ? '0 : ext_last;
			end
			if (state_q == susf_pkg::ST_Q_EMIT && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q       <= susf_pkg::SYM_W'(digit);
			wrap_q    <= (32'(pos_q) == NL - 1);
			fin_q     <= (op == susf_pkg::OP_FINAL);
			walk_id_q <= number_index;
			base_q    <= susf_pkg::DA_W'((32'(number_index) - 32'd1) * NL);
			t_q       <= '0;
			best_q    <= susf_pkg::BEST_W'(NL + 1);
			lo_q      <= '0;
			hi_q      <= '0;
		end
		unique case (state_q)
			susf_pkg::ST_E_LAST: begin
				len_p_q <= info_rd.len;
				p_q     <= last_q;
				if (tgt_c != '0) begin
					q_q          <= tgt_c;
					split_last_q <= 1'b1;
				end else begin
					cur_q     <= susf_pkg::ST_W'(count_q);
					cur_len_q <= susf_pkg::LEN_W'(info_rd.len + 1'b1);
				end
			end
			susf_pkg::ST_E_WALK: begin
				if (tgt_c != '0) begin
					q_q          <= tgt_c;
					len_p_q      <= info_rd.len;
					split_last_q <= 1'b0;
				end else begin
					p_q <= info_rd.link;
				end
			end
			susf_pkg::ST_E_Q: begin
				nq_q    <= susf_pkg::ST_W'(count_q);
				len_q_q <= info_rd.len;
			end
			susf_pkg::ST_E_SWALK: begin
				p_q <= info_rd.link;
			end
			susf_pkg::ST_F_CLEAR: begin
				walk_id_q <= susf_pkg::IDX_W'(1);
				base_q    <= '0;
				t_q       <= '0;
			end
			susf_pkg::ST_W_DIG: begin
				t_q <= susf_pkg::POS_W'(t_q + 1'b1);
				if (t_q != '0) begin
					dig_q[susf_pkg::DIDX_W'(t_q - 1'b1)] <= dig_rd;
				end
				k_q <= '0;
			end
			susf_pkg::ST_W_ROOT: begin
				j_q      <= k_q;
				have_x_q <= 1'b0;
			end
			susf_pkg::ST_W_STEP: begin
				if (have_x_q && !fin_q && better) begin
					best_q <= susf_pkg::BEST_W'(sub_len);
					lo_q   <= susf_pkg::POS_W'(k_q + 1'b1);
					hi_q   <= j_q;
				end
				if (!walk_end) begin
					x_q      <= walk_nx;
					j_q      <= susf_pkg::POS_W'(j_q + 1'b1);
					have_x_q <= 1'b1;
				end else if (!last_k) begin
					k_q <= susf_pkg::POS_W'(k_q + 1'b1);
				end else if (fin_q) begin
					walk_id_q <= susf_pkg::IDX_W'(walk_id_q + 1'b1);
					base_q    <= susf_pkg::DA_W'(base_q + susf_pkg::DA_W'(NL));
					t_q       <= '0;
				end
			end
			susf_pkg::ST_Q_EMIT: begin
				if (emit) begin
					found_q <= (32'(best_q) <= NL);
					start_q <= susf_pkg::OPOS_W'(lo_q);
					end_q   <= susf_pkg::OPOS_W'(hi_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/susf_checker.sv -----
// ----------------------------------------------------------------------------
// susf_checker
// Port-level checks of the shortest unique substring finder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module susf_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic [susf_pkg::OP_W-1:0]    op,
	input wire logic [susf_pkg::DIGIT_W-1:0] digit,
	input wire logic [susf_pkg::IDX_W-1:0]   number_index,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic                         found,
	input wire logic [susf_pkg::OPOS_W-1:0]  start_pos,
	input wire logic [susf_pkg::OPOS_W-1:0]  end_pos
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(found) && $stable(start_pos) && $stable(end_pos))
		else $error("result changed while stalled");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> start_pos == '0 && end_pos == '0)
		else $error("empty result carries positions");

	a_found_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> start_pos != '0 && start_pos <= end_pos
			&& 32'(end_pos) <= susf_pkg::NUMBER_LENGTH)
		else $error("found span out of order");

endmodule

bind shortest_unique_substring_finder_unit susf_checker u_susf_checker (.*);

`default_nettype wire
